>>> design/u8bmp_pkg.sv
package u8bmp_pkg;

  // Length classes of an open sequence.
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;
  localparam logic [2:0] LEN_FIVE  = 3'd5;
  localparam logic [2:0] LEN_SIX   = 3'd6;

  // Default depth of the result queue; a power of two, at least 2.
  localparam int unsigned RESULT_DEPTH = 4;

  typedef struct packed {
    logic [15:0] code_point;
    logic        is_error;
    logic [2:0]  byte_count;
    logic        final_result;
  } result_t;

  typedef struct packed {
    logic       emit;   // the byte is a complete result on its own
    result_t    res;
    logic       opens;  // the byte opens a multi-byte sequence
    logic [2:0] limit;
  } lead_t;

  // Classify a byte seen with no sequence open.
  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l = '0;
    if (b < 8'h80) begin
      l.emit           = 1'b1;
      l.res.code_point = {8'h00, b};
      l.res.byte_count = LEN_ONE;
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      l.emit           = 1'b1;
      l.res.is_error   = 1'b1;
      l.res.byte_count = LEN_ONE;
    end else begin
      l.opens = 1'b1;
      if (b < 8'hE0) begin
        l.limit = LEN_TWO;
      end else if (b < 8'hF0) begin
        l.limit = LEN_THREE;
      end else if (b < 8'hF8) begin
        l.limit = LEN_FOUR;
      end else if (b < 8'hFC) begin
        l.limit = LEN_FIVE;
      end else begin
        l.limit = LEN_SIX;
      end
    end
    return l;
  endfunction

endpackage

>>> design/utf8_bmp_decoder_validator.sv
// Channel   Handshake                    Payload
// input     byte_valid / byte_ready      byte_value[7:0], stream_end
// result    result_valid / result_ready  code_point[15:0], is_error, byte_count[2:0],
//                                        final_result
//
// One byte is taken per clock while byte_ready is high; its results enter the result
// queue at that same edge and are shown from the next cycle on, one result per cycle
// while result_ready is high. A byte may give up to two results, so the input takes a
// beat whenever the queue has two free slots; the single output port of the queue sets
// the sustained rate when many bytes give two results.
// Reset (rst, synchronous) closes any open sequence and empties the queue.
// A stall on the result side only fills the queue; nothing is dropped or repeated.
module utf8_bmp_decoder_validator #(
  parameter int unsigned ResultDepth = u8bmp_pkg::RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  byte_value,
  input  logic        stream_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] code_point,
  output logic        is_error,
  output logic [2:0]  byte_count,
  output logic        final_result
);
  import u8bmp_pkg::*;

  localparam int unsigned PtrW = (ResultDepth > 1) ? $clog2(ResultDepth) : 1;
  localparam int unsigned CntW = $clog2(ResultDepth + 1);

  // Decoder state: the open sequence.
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [2:0] bytes_gathered, bytes_gathered_next;
  logic [2:0] bytes_limit, bytes_limit_next;

  // Result queue, written up to two entries per beat and read one per cycle while result_ready is high.
  result_t           queue [ResultDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   fill;

  result_t r0, r1;
  logic    r0_valid, r1_valid;
  logic    take, give;

  assign byte_ready   = (fill <= CntW'(ResultDepth - 2));
  assign take         = byte_valid && byte_ready;
  assign result_valid = (fill != '0);
  assign give         = result_valid && result_ready;

  // Step logic: the state after this byte and the zero, one or two results it causes.
  always_comb begin
    lead_t      ld;
    logic       cont;
    logic       lead_now;   // the byte is decoded as a lead in this beat
    logic       second_slot;
    logic [2:0] grown;
    logic       surrogate, overlong;

    ld               = lead_decode(byte_value);
    cont             = (byte_value[7:6] == 2'b10);
    lead_now         = 1'b0;
    second_slot      = 1'b0;
    grown            = bytes_gathered + 3'd1;
    surrogate        = (lead_byte[3:0] == 4'hD) && ((second_byte & 8'h3C) >= 8'h20);
    overlong         = (lead_byte == 8'hE0) && (second_byte[7:5] == 3'b100);
    r0               = '0;
    r1               = '0;
    r0_valid         = 1'b0;
    r1_valid         = 1'b0;
    lead_byte_next   = lead_byte;
    second_byte_next = second_byte;
    bytes_gathered_next = bytes_gathered;
    bytes_limit_next    = bytes_limit;

    if (bytes_gathered == LEN_NONE) begin
      lead_now = 1'b1;
    end else if (bytes_limit >= LEN_FOUR) begin
      // Long leads swallow high-bit bytes up to their limit as one error.
      if (byte_value[7]) begin
        if (grown >= bytes_limit) begin
          r0_valid            = 1'b1;
          r0.is_error         = 1'b1;
          r0.byte_count       = bytes_limit;
          bytes_gathered_next = LEN_NONE;
          bytes_limit_next    = LEN_NONE;
        end else begin
          bytes_gathered_next = grown;
        end
      end else begin
        r0_valid      = 1'b1;
        r0.is_error   = 1'b1;
        r0.byte_count = bytes_gathered;
        lead_now      = 1'b1;
        second_slot   = 1'b1;
      end
    end else if (!cont) begin
      // Sequence ended early; the offending byte starts over as a lead.
      r0_valid      = 1'b1;
      r0.is_error   = 1'b1;
      r0.byte_count = bytes_gathered;
      lead_now      = 1'b1;
      second_slot   = 1'b1;
    end else if (bytes_limit == LEN_THREE) begin
      if (bytes_gathered == LEN_ONE) begin
        second_byte_next    = byte_value;
        bytes_gathered_next = LEN_TWO;
      end else begin
        r0_valid      = 1'b1;
        r0.byte_count = LEN_THREE;
        if (surrogate || overlong) begin
          r0.is_error = 1'b1;
        end else begin
          r0.code_point = {lead_byte[3:0], second_byte[5:0], byte_value[5:0]};
        end
        bytes_gathered_next = LEN_NONE;
        bytes_limit_next    = LEN_NONE;
      end
    end else begin
      r0_valid      = 1'b1;
      r0.byte_count = LEN_TWO;
      if (lead_byte[7:1] == 7'b1100000) begin
        r0.is_error = 1'b1;
      end else begin
        r0.code_point = {5'd0, lead_byte[4:0], byte_value[5:0]};
      end
      bytes_gathered_next = LEN_NONE;
      bytes_limit_next    = LEN_NONE;
    end

    if (lead_now) begin
      bytes_gathered_next = LEN_NONE;
      bytes_limit_next    = LEN_NONE;
      if (ld.opens) begin
        lead_byte_next      = byte_value;
        bytes_gathered_next = LEN_ONE;
        bytes_limit_next    = ld.limit;
      end else if (ld.emit && second_slot) begin
        r1_valid = 1'b1;
        r1       = ld.res;
      end else if (ld.emit) begin
        r0_valid = 1'b1;
        r0       = ld.res;
      end
    end

    // Stream end flushes whatever is still open as one error.
    if (stream_end && bytes_gathered_next != LEN_NONE) begin
      if (r0_valid) begin
        r1_valid      = 1'b1;
        r1.is_error   = 1'b1;
        r1.byte_count = bytes_gathered_next;
      end else begin
        r0_valid      = 1'b1;
        r0.is_error   = 1'b1;
        r0.byte_count = bytes_gathered_next;
      end
      bytes_gathered_next = LEN_NONE;
      bytes_limit_next    = LEN_NONE;
    end

    if (stream_end) begin
      if (r1_valid) begin
        r1.final_result = 1'b1;
      end else if (r0_valid) begin
        r0.final_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte      <= '0;
      second_byte    <= '0;
      bytes_gathered <= LEN_NONE;
      bytes_limit    <= LEN_NONE;
    end else if (take) begin
      lead_byte      <= lead_byte_next;
      second_byte    <= second_byte_next;
      bytes_gathered <= bytes_gathered_next;
      bytes_limit    <= bytes_limit_next;
    end
  end

  // The second result only exists when the first does, so it always lands one slot later.
  logic [PtrW-1:0] wr_ptr_plus;
  logic [1:0]      pushes;
  assign wr_ptr_plus = wr_ptr + PtrW'(1);
  assign pushes      = take ? ({1'b0, r0_valid} + {1'b0, r1_valid}) : 2'd0;

  always_ff @(posedge clk) begin
    if (take && r0_valid) begin
      queue[wr_ptr] <= r0;
    end
    if (take && r1_valid) begin
      queue[wr_ptr_plus] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(pushes);
      if (give) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      fill <= fill + CntW'(pushes) - CntW'(give);
    end
  end

  assign code_point   = queue[rd_ptr].code_point;
  assign is_error     = queue[rd_ptr].is_error;
  assign byte_count   = queue[rd_ptr].byte_count;
  assign final_result = queue[rd_ptr].final_result;

  // The queue never holds more results than it has slots.
  assert property (@(posedge clk) disable iff (rst) fill <= CntW'(ResultDepth))
    else $error("result queue overfilled");

  // A stream-end byte always leaves no sequence open.
  assert property (@(posedge clk) disable iff (rst)
    (take && stream_end) |=> (bytes_gathered == LEN_NONE))
    else $error("sequence left open after stream end");

  // An open sequence has gathered fewer bytes than its length class.
  assert property (@(posedge clk) disable iff (rst)
    (bytes_gathered != LEN_NONE) |-> (bytes_gathered < bytes_limit))
    else $error("open sequence reached its limit");

  // Error results carry no code point.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_error) |-> (code_point == 16'h0000))
    else $error("error result with a code point");

endmodule

>>> tb/tb_utf8_bmp_decoder_validator.sv
module tb_utf8_bmp_decoder_validator;
  import u8bmp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  byte_value;
  logic        stream_end;
  logic        result_valid;
  logic        result_ready;
  logic [15:0] code_point;
  logic        is_error;
  logic [2:0]  byte_count;
  logic        final_result;

  utf8_bmp_decoder_validator uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_value   (byte_value),
    .stream_end   (stream_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .is_error     (is_error),
    .byte_count   (byte_count),
    .final_result (final_result)
  );

  // Free-running clock with a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as the testbench expects it to be after each accepted byte.
  logic [7:0] seq_lead   = 8'h00;
  logic [7:0] seq_second = 8'h00;
  logic [2:0] seq_count  = LEN_NONE;
  logic [2:0] seq_limit  = LEN_NONE;

  // Results caused by the byte being decoded, and all results still owed by the block.
  result_t step_results[$];
  result_t expected_results[$];

  int mismatches = 0;
  int bytes_sent = 0;

  // Idle controls. When a mode bit is set, that side draws a random wait before each
  // beat; when it is clear, the side runs flat out. A nonzero hold request makes the
  // receiver refuse results for that many cycles, once.
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int sink_hold = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  function automatic void emit(input logic [15:0] cp, input logic err, input logic [2:0] cnt);
    result_t r;
    r.code_point   = cp;
    r.is_error     = err;
    r.byte_count   = cnt;
    r.final_result = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void close_sequence();
    seq_count = LEN_NONE;
    seq_limit = LEN_NONE;
  endfunction

  // Decode a byte that arrives with no sequence open: ASCII and invalid leads give a
  // result at once, valid leads open a sequence of the class the lead announces.
  function automatic void start_char(input logic [7:0] b);
    if (b < 8'h80) begin
      emit({8'h00, b}, 1'b0, LEN_ONE);
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      emit(16'h0000, 1'b1, LEN_ONE);
    end else begin
      seq_lead  = b;
      seq_count = LEN_ONE;
      if (b < 8'hE0) begin
        seq_limit = LEN_TWO;
      end else if (b < 8'hF0) begin
        seq_limit = LEN_THREE;
      end else if (b < 8'hF8) begin
        seq_limit = LEN_FOUR;
      end else if (b < 8'hFC) begin
        seq_limit = LEN_FIVE;
      end else begin
        seq_limit = LEN_SIX;
      end
    end
  endfunction

  // Advance the expected decoder state by one accepted byte and queue the results the
  // block owes for it.
  function automatic void decode_expect(input logic [7:0] b, input logic last);
    logic is_cont;
    logic surrogate;
    logic overlong;
    is_cont = (b[7:6] == 2'b10);
    step_results.delete();
    if (seq_count == LEN_NONE) begin
      start_char(b);
    end else if (seq_limit >= LEN_FOUR) begin
      // Leads beyond the plane swallow high-bit bytes up to their length class.
      if (b[7]) begin
        seq_count = seq_count + 3'd1;
        if (seq_count >= seq_limit) begin
          emit(16'h0000, 1'b1, seq_limit);
          close_sequence();
        end
      end else begin
        emit(16'h0000, 1'b1, seq_count);
        close_sequence();
        start_char(b);
      end
    end else if (!is_cont) begin
      // The bad byte is not part of the error; it starts over as a lead.
      emit(16'h0000, 1'b1, seq_count);
      close_sequence();
      start_char(b);
    end else if (seq_limit == LEN_THREE) begin
      if (seq_count == LEN_ONE) begin
        seq_second = b;
        seq_count  = LEN_TWO;
      end else begin
        surrogate = (seq_lead[3:0] == 4'hD) && seq_second[5];
        overlong  = (seq_lead == 8'hE0) && (seq_second[7:5] == 3'b100);
        if (surrogate || overlong) begin
          emit(16'h0000, 1'b1, LEN_THREE);
        end else begin
          emit({seq_lead[3:0], seq_second[5:0], b[5:0]}, 1'b0, LEN_THREE);
        end
        close_sequence();
      end
    end else begin
      if (seq_lead[7:1] == 7'b1100000) begin
        emit(16'h0000, 1'b1, LEN_TWO);
      end else begin
        emit({5'b00000, seq_lead[4:0], b[5:0]}, 1'b0, LEN_TWO);
      end
      close_sequence();
    end
    // The end of the stream flushes whatever is still open as one more error.
    if (last && seq_count != LEN_NONE) begin
      emit(16'h0000, 1'b1, seq_count);
      close_sequence();
    end
    if (last && step_results.size() > 0) begin
      step_results[step_results.size() - 1].final_result = 1'b1;
    end
    foreach (step_results[i]) begin
      expected_results.push_back(step_results[i]);
    end
  endfunction

  // Offer one byte beat and hold it until the block takes it. Called and returns at a
  // falling edge; the prediction is made at the rising edge that accepts the beat.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_value <= b;
    stream_end <= last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_expect(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Receiver: waits a drawn number of cycles before each result beat, or the long hold
  // when one is requested, then keeps ready high until a result is taken.
  initial begin : result_sink
    int wait_cycles;
    result_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = sink_gaps ? $urandom_range(0, 9) : 0;
      if (sink_hold > 0) begin
        wait_cycles = sink_hold;
        sink_hold   = 0;
      end
      if (wait_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Every result beat is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%h err=%b cnt=%0d fin=%b",
                                  code_point, is_error, byte_count, final_result));
      end else begin
        want = expected_results.pop_front();
        if (code_point !== want.code_point) begin
          report_mismatch($sformatf("code_point %h, expected %h", code_point, want.code_point));
        end
        if (is_error !== want.is_error) begin
          report_mismatch($sformatf("is_error %b, expected %b", is_error, want.is_error));
        end
        if (byte_count !== want.byte_count) begin
          report_mismatch($sformatf("byte_count %0d, expected %0d", byte_count, want.byte_count));
        end
        if (final_result !== want.final_result) begin
          report_mismatch($sformatf("final_result %b, expected %b", final_result,
                                    want.final_result));
        end
      end
    end
  end

  // Smallest and largest ASCII values, a stray continuation byte and the top byte.
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // A valid two-byte character and an overlong two-byte form.
  task automatic test_two_byte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // An overlong E0 form, an encoded surrogate and the largest code point.
  task automatic test_three_byte();
    send_byte(8'hE0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // A sequence cut short by FE: the cut gives one error and FE gives a second one
  // in the same beat.
  task automatic test_broken_sequences();
    send_byte(8'hE2, 1'b0);
    send_byte(8'hFE, 1'b0);
  endtask

  // A four-byte lead that reaches its limit, and a six-byte lead cut short by ASCII.
  task automatic test_long_leads();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFC, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // Stream end on a byte that both cuts a sequence and opens a new one, so the open
  // lead is flushed as a second error; then stream end on a plain character.
  task automatic test_stream_end();
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  // The receiver stops for a long stretch while bytes keep coming, many of them giving
  // two results, so the result queue fills and the input must stall.
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 80;
    repeat (20) begin
      send_byte(8'hE2, 1'b0);
      send_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Mostly well-formed characters with random content, plus cut sequences, long leads
  // and raw noise. Stream end falls at random; idle modes change now and then.
  task automatic test_random_stream(input int count);
    int kind;
    int len;
    logic [7:0] lead;
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 59) == 0) begin
        src_gaps  = 1'($urandom_range(0, 1));
        sink_gaps = 1'($urandom_range(0, 1));
      end
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_byte(8'($urandom_range(8'h00, 8'h7F)), $urandom_range(0, 39) == 0);
      end else if (kind < 50) begin
        send_byte(8'($urandom_range(8'hC0, 8'hDF)), $urandom_range(0, 39) == 0);
        send_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 39) == 0);
      end else if (kind < 75) begin
        // Favor E0 and ED so that overlong and surrogate forms show up often.
        if ($urandom_range(0, 3) == 0) begin
          lead = $urandom_range(0, 1) ? 8'hE0 : 8'hED;
        end else begin
          lead = 8'($urandom_range(8'hE0, 8'hEF));
        end
        send_byte(lead, $urandom_range(0, 39) == 0);
        send_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 39) == 0);
        send_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 39) == 0);
      end else if (kind < 83) begin
        lead = 8'($urandom_range(8'hF0, 8'hFD));
        len  = (lead < 8'hF8) ? 4 : (lead < 8'hFC) ? 5 : 6;
        send_byte(lead, $urandom_range(0, 39) == 0);
        for (int i = 1; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_byte(8'($urandom_range(8'h00, 8'h7F)), $urandom_range(0, 39) == 0);
            break;
          end
          send_byte(8'($urandom_range(8'h80, 8'hFF)), $urandom_range(0, 39) == 0);
        end
      end else if (kind < 92) begin
        lead = 8'($urandom_range(8'hC2, 8'hEF));
        send_byte(lead, $urandom_range(0, 39) == 0);
        if (lead >= 8'hE0 && $urandom_range(0, 1)) begin
          send_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 39) == 0);
        end
        // Any byte that is not a continuation breaks the sequence.
        if ($urandom_range(0, 1)) begin
          send_byte(8'($urandom_range(8'h00, 8'h7F)), $urandom_range(0, 39) == 0);
        end else begin
          send_byte(8'($urandom_range(8'hC0, 8'hFF)), $urandom_range(0, 39) == 0);
        end
      end else begin
        send_byte(8'($urandom_range(8'h00, 8'hFF)), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_value = 8'h00;
    stream_end = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_bytes();
    test_two_byte();
    test_three_byte();
    test_broken_sequences();
    test_long_leads();
    test_stream_end();
    test_backpressure();
    test_random_stream(1280);

    byte_valid <= 1'b0;
    stream_end <= 1'b0;
    // Drain every owed result, then keep the clock running to catch anything stray.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS utf8_bmp_decoder_validator");
    end else begin
      $display("FAIL utf8_bmp_decoder_validator");
    end
    $finish;
  end

  // Guard against a hung handshake; far above the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("FAIL utf8_bmp_decoder_validator");
    $finish;
  end

endmodule
